FILE: src/ride_calorie_and_zone_tracker_top_macros.svh
// Assertion macros shared by the tracker checker
`ifndef RIDE_CALORIE_AND_ZONE_TRACKER_TOP_MACROS_SVH
`define RIDE_CALORIE_AND_ZONE_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RCZT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RCZT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rczt_pkg.sv
// Shared types and constants of the ride calorie and zone tracker
package rczt_pkg;

    localparam int HEART_ZONES_DEF = 5;
    localparam int POWER_ZONES_DEF = 7;
    localparam int HR_TABLE_LEN    = 5;
    localparam int PWR_TABLE_LEN   = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int ADD_W      = 20;
    localparam int KCAL_W     = 48;
    localparam int ZONE_W     = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] ZONE_NONE = 4'hF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT   = 3'd0,
        CFG_FEMALE   = 3'd1,
        CFG_AGE      = 3'd2,
        CFG_MAX_HR   = 3'd3,
        CFG_LTHR     = 3'd4,
        CFG_BY_LTHR  = 3'd5,
        CFG_FTP      = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_POWER = 2'd1,
        SRC_HEART = 2'd2,
        SRC_SPEED = 2'd3
    } kcal_src_t;

    typedef struct packed {
        logic                  we;
        cfg_index_t            index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        kcal_src_t         source;
        logic [ADD_W-1:0]  add;
        logic              hr_en;
        logic [ZONE_W-1:0] hr_zone;
        logic              pwr_en;
        logic [ZONE_W-1:0] pwr_zone;
        logic [31:0]       session_ms;
    } q_item_t;

    localparam logic [7:0] HR_PCT_MAX  [HR_TABLE_LEN] = '{8'd50, 8'd60, 8'd70, 8'd80, 8'd90};
    localparam logic [7:0] HR_PCT_LTHR [HR_TABLE_LEN] = '{8'd68, 8'd85, 8'd90, 8'd95, 8'd100};
    localparam logic [7:0] PWR_PCT [PWR_TABLE_LEN] =
        '{8'd0, 8'd55, 8'd75, 8'd90, 8'd105, 8'd120, 8'd150};

    localparam int WEIGHT_DEFAULT = 75;
    localparam int AGE_DEFAULT    = 35;
    localparam int AGE_MAX_KNOWN  = 119;
    localparam int MAXHR_BASE     = 220;
    localparam int MAXHR_DEFAULT  = 180;
    localparam int LTHR_PCT       = 89;
    localparam int PCT_SCALE      = 100;
    localparam int PCT_ROUND      = 50;

    localparam int M_BPM = 6309;
    localparam int M_KG  = 1988;
    localparam int M_AGE = 2017;
    localparam int M_OFS = 550969;
    localparam int F_BPM = 4472;
    localparam int F_KG  = 1263;
    localparam int F_AGE = 740;
    localparam int F_OFS = 204022;

    // Rounded scaled quotients, reduced fractions, reciprocal multiply
    localparam int PWR_SCALE_SH = 15;
    localparam int PWR_BIAS     = 247;
    localparam int PWR_DIV      = 495;
    localparam int PWR_SHIFT    = 37;
    localparam logic [31:0] PWR_RECIP =
        32'(((64'd1 << PWR_SHIFT) + PWR_DIV - 1) / PWR_DIV);

    localparam int HR_SCALE_SH = 10;
    localparam int HR_BIAS     = 19612;
    localparam int HR_DIV      = 39225;
    localparam int HR_SHIFT    = 47;
    localparam logic [31:0] HR_RECIP =
        32'(((64'd1 << HR_SHIFT) + HR_DIV - 1) / HR_DIV);

    localparam int SPD_SCALE_SH = 11;
    localparam int SPD_BIAS     = 562;
    localparam int SPD_DIV      = 1125;
    localparam int SPD_SHIFT    = 38;
    localparam logic [31:0] SPD_RECIP =
        32'(((64'd1 << SPD_SHIFT) + SPD_DIV - 1) / SPD_DIV);

    localparam int LTHR_DIV   = 100;
    localparam int LTHR_SHIFT = 24;
    localparam logic [31:0] LTHR_RECIP =
        32'(((64'd1 << LTHR_SHIFT) + LTHR_DIV - 1) / LTHR_DIV);

endpackage

FILE: src/rczt_if.sv
// Item channel interfaces of the tracker: sample input and report output
interface rczt_sample_if;
    logic        valid;
    logic        ready;
    logic        paused;
    logic        power_live;
    logic [11:0] power_watts;
    logic        hr_live;
    logic [7:0]  heart_bpm;
    logic        speed_sensor_live;
    logic [10:0] sensor_speed;
    logic        gps_fresh;
    logic [10:0] gps_speed;
    logic [31:0] session_ms;

    modport source (
        output valid, paused, power_live, power_watts, hr_live, heart_bpm,
               speed_sensor_live, sensor_speed, gps_fresh, gps_speed, session_ms,
        input  ready
    );
    modport sink (
        input  valid, paused, power_live, power_watts, hr_live, heart_bpm,
               speed_sensor_live, sensor_speed, gps_fresh, gps_speed, session_ms,
        output ready
    );
endinterface

interface rczt_report_if;
    logic               valid;
    logic               ready;
    logic [47:0]        kcal_total_q16;
    logic [1:0]         kcal_source;
    logic signed [3:0]  hr_zone_now;
    logic [31:0]        hr_zone_time_ms;
    logic signed [3:0]  power_zone_now;
    logic [31:0]        power_zone_time_ms;
    logic [31:0]        zone_since_ms;

    modport source (
        output valid, kcal_total_q16, kcal_source, hr_zone_now, hr_zone_time_ms,
               power_zone_now, power_zone_time_ms, zone_since_ms,
        input  ready
    );
    modport sink (
        input  valid, kcal_total_q16, kcal_source, hr_zone_now, hr_zone_time_ms,
               power_zone_now, power_zone_time_ms, zone_since_ms,
        output ready
    );
endinterface

FILE: src/rczt_front.sv
// Front pipeline: config registers, calorie source choice, burn and zone classification
module rczt_front
    import rczt_pkg::*;
#(
    parameter int HEART_ZONES = HEART_ZONES_DEF,
    parameter int POWER_ZONES = POWER_ZONES_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_wr_t      cfg,
    rczt_sample_if.sink  sample,
    output logic         push_valid,
    output q_item_t      push_item,
    input  logic         push_ready
);

    localparam int HR_N  = (HEART_ZONES < HR_TABLE_LEN) ? HEART_ZONES : HR_TABLE_LEN;
    localparam int PWR_N = (POWER_ZONES < PWR_TABLE_LEN) ? POWER_ZONES : PWR_TABLE_LEN;

    function automatic logic [7:0] met_tenths(input logic [10:0] s);
        logic [7:0] m;
        if (s == 11'd0)        m = 8'd0;
        else if (s < 11'd160)  m = 8'd42;
        else if (s < 11'd192)  m = 8'd63;
        else if (s < 11'd224)  m = 8'd84;
        else if (s < 11'd256)  m = 8'd105;
        else if (s < 11'd306)  m = 8'd126;
        else if (s < 11'd320)  m = 8'd147;
        else                   m = 8'd168;
        return m;
    endfunction

    logic [7:0]  weight_reg;
    logic        female_reg;
    logic [6:0]  age_reg;
    logic [7:0]  max_hr_reg;
    logic [7:0]  lthr_reg;
    logic        by_lthr_reg;
    logic [11:0] ftp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg  <= '0;
            female_reg  <= 1'b0;
            age_reg     <= '0;
            max_hr_reg  <= '0;
            lthr_reg    <= '0;
            by_lthr_reg <= 1'b0;
            ftp_reg     <= '0;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                CFG_WEIGHT:  weight_reg  <= cfg.data[7:0];
                CFG_FEMALE:  female_reg  <= cfg.data[0];
                CFG_AGE:     age_reg     <= cfg.data[6:0];
                CFG_MAX_HR:  max_hr_reg  <= cfg.data[7:0];
                CFG_LTHR:    lthr_reg    <= cfg.data[7:0];
                CFG_BY_LTHR: by_lthr_reg <= cfg.data[0];
                CFG_FTP:     ftp_reg     <= cfg.data[11:0];
                default:     ;
            endcase
        end
    end

    logic adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    assign adv          = !s4_valid_reg || push_ready;
    assign sample.ready = adv;
    assign push_valid   = s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= sample.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: rider defaults, heart-rate terms, speed MET
    logic [6:0]  known_age;
    logic [6:0]  age_cal;
    logic [7:0]  kg;
    logic [7:0]  maxhr_next;
    logic [14:0] lthr_num_next;
    logic [10:0] spd;
    logic [7:0]  met;
    logic [21:0] hr_pos_next, hr_neg_next;
    logic [26:0] x_p_next;
    logic [15:0] mk_next;

    always_comb
    begin
        known_age = (age_reg >= 7'd1 && age_reg <= 7'(AGE_MAX_KNOWN)) ? age_reg : 7'd0;
        age_cal   = (known_age != 7'd0) ? known_age : 7'(AGE_DEFAULT);
        kg        = (weight_reg != 8'd0) ? weight_reg : 8'(WEIGHT_DEFAULT);
        if (max_hr_reg != 8'd0)
            maxhr_next = max_hr_reg;
        else if (known_age != 7'd0)
            maxhr_next = 8'(MAXHR_BASE) - {1'b0, known_age};
        else
            maxhr_next = 8'(MAXHR_DEFAULT);
        lthr_num_next = 15'(maxhr_next) * 15'(LTHR_PCT) + 15'(PCT_ROUND);
        spd = sample.speed_sensor_live ? sample.sensor_speed : sample.gps_speed;
        met = met_tenths(spd);
        mk_next = 16'(met) * 16'(kg);
        if (female_reg)
        begin
            hr_pos_next = 22'(sample.heart_bpm) * 22'(F_BPM) + 22'(age_cal) * 22'(F_AGE);
            hr_neg_next = 22'(kg) * 22'(F_KG) + 22'(F_OFS);
        end
        else
        begin
            hr_pos_next = 22'(sample.heart_bpm) * 22'(M_BPM) + 22'(kg) * 22'(M_KG)
                        + 22'(age_cal) * 22'(M_AGE);
            hr_neg_next = 22'(M_OFS);
        end
        x_p_next = {sample.power_watts, {PWR_SCALE_SH{1'b0}}} + 27'(PWR_BIAS);
    end

    logic        s1_paused_reg, s1_power_live_reg, s1_hr_live_reg, s1_spd_live_reg;
    logic [11:0] s1_watts_reg;
    logic [7:0]  s1_bpm_reg;
    logic [31:0] s1_session_reg;
    logic [7:0]  s1_maxhr_reg;
    logic [14:0] s1_lthr_num_reg;
    logic [21:0] s1_hr_pos_reg, s1_hr_neg_reg;
    logic [26:0] s1_x_p_reg;
    logic [15:0] s1_mk_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_paused_reg     <= sample.paused;
            s1_power_live_reg <= sample.power_live;
            s1_hr_live_reg    <= sample.hr_live;
            s1_spd_live_reg   <= sample.speed_sensor_live || sample.gps_fresh;
            s1_watts_reg      <= sample.power_watts;
            s1_bpm_reg        <= sample.heart_bpm;
            s1_session_reg    <= sample.session_ms;
            s1_maxhr_reg      <= maxhr_next;
            s1_lthr_num_reg   <= lthr_num_next;
            s1_hr_pos_reg     <= hr_pos_next;
            s1_hr_neg_reg     <= hr_neg_next;
            s1_x_p_reg        <= x_p_next;
            s1_mk_reg         <= mk_next;
        end
    end

    // Stage 2: threshold rate, scaled numerators
    logic [32:0] lthr_prod;
    logic [7:0]  lthr_next;
    logic        hr_ok_next;
    logic [20:0] hr_n;
    logic [30:0] x_hr_next;
    logic [26:0] x_s_next;

    always_comb
    begin
        lthr_prod  = 33'(s1_lthr_num_reg) * 33'(LTHR_RECIP);
        lthr_next  = (lthr_reg != 8'd0) ? lthr_reg : 8'(lthr_prod >> LTHR_SHIFT);
        hr_ok_next = s1_hr_pos_reg > s1_hr_neg_reg;
        hr_n       = 21'(s1_hr_pos_reg - s1_hr_neg_reg);
        x_hr_next  = {hr_n, {HR_SCALE_SH{1'b0}}} + 31'(HR_BIAS);
        x_s_next   = {s1_mk_reg, {SPD_SCALE_SH{1'b0}}} + 27'(SPD_BIAS);
    end

    logic        s2_paused_reg, s2_power_live_reg, s2_hr_live_reg, s2_spd_live_reg;
    logic [11:0] s2_watts_reg;
    logic [7:0]  s2_bpm_reg;
    logic [31:0] s2_session_reg;
    logic [7:0]  s2_maxhr_reg, s2_lthr_reg;
    logic        s2_hr_ok_reg;
    logic [26:0] s2_x_p_reg, s2_x_s_reg;
    logic [30:0] s2_x_hr_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_paused_reg     <= s1_paused_reg;
            s2_power_live_reg <= s1_power_live_reg;
            s2_hr_live_reg    <= s1_hr_live_reg;
            s2_spd_live_reg   <= s1_spd_live_reg;
            s2_watts_reg      <= s1_watts_reg;
            s2_bpm_reg        <= s1_bpm_reg;
            s2_session_reg    <= s1_session_reg;
            s2_maxhr_reg      <= s1_maxhr_reg;
            s2_lthr_reg       <= lthr_next;
            s2_hr_ok_reg      <= hr_ok_next;
            s2_x_p_reg        <= s1_x_p_reg;
            s2_x_s_reg        <= x_s_next;
            s2_x_hr_reg       <= x_hr_next;
        end
    end

    // Stage 3: quotients, source choice, zones
    logic [58:0]       prod_p, prod_s;
    logic [62:0]       prod_hr;
    kcal_src_t         source_next;
    logic [7:0]        hr_ref;
    logic [7:0]        hr_pct;
    logic [14:0]       bpm_scaled;
    logic [15:0]       hr_low;
    logic [ZONE_W-1:0] hr_zone_next;
    logic [18:0]       w_scaled;
    logic [19:0]       pwr_low;
    logic [ZONE_W-1:0] pwr_zone_next;

    always_comb
    begin
        prod_p  = 59'(s2_x_p_reg) * 59'(PWR_RECIP);
        prod_hr = 63'(s2_x_hr_reg) * 63'(HR_RECIP);
        prod_s  = 59'(s2_x_s_reg) * 59'(SPD_RECIP);

        if (s2_paused_reg)
            source_next = SRC_NONE;
        else if (s2_power_live_reg)
            source_next = SRC_POWER;
        else if (s2_hr_live_reg && s2_bpm_reg != 8'd0)
            source_next = SRC_HEART;
        else if (s2_spd_live_reg)
            source_next = SRC_SPEED;
        else
            source_next = SRC_NONE;

        hr_ref       = by_lthr_reg ? s2_lthr_reg : s2_maxhr_reg;
        bpm_scaled   = 15'(s2_bpm_reg) * 15'(PCT_SCALE) + 15'(PCT_ROUND);
        hr_zone_next = '0;
        for (int i = 1; i <= HR_N; i++)
        begin
            hr_pct = by_lthr_reg ? HR_PCT_LTHR[i-1] : HR_PCT_MAX[i-1];
            hr_low = 16'(hr_ref) * 16'(hr_pct);
            if (16'(bpm_scaled) > hr_low)
                hr_zone_next = ZONE_W'(i);
        end

        w_scaled      = 19'(s2_watts_reg) * 19'(PCT_SCALE) + 19'(PCT_ROUND);
        pwr_zone_next = '0;
        for (int i = 1; i <= PWR_N; i++)
        begin
            pwr_low = 20'(ftp_reg) * 20'(PWR_PCT[i-1]);
            if (20'(w_scaled) > pwr_low)
                pwr_zone_next = ZONE_W'(i);
        end
    end

    kcal_src_t         s3_source_reg;
    logic [ADD_W-1:0]  s3_add_p_reg, s3_add_hr_reg, s3_add_s_reg;
    logic              s3_hr_en_reg, s3_pwr_en_reg;
    logic [ZONE_W-1:0] s3_hr_zone_reg, s3_pwr_zone_reg;
    logic [31:0]       s3_session_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_source_reg   <= source_next;
            s3_add_p_reg    <= ADD_W'(prod_p >> PWR_SHIFT);
            s3_add_hr_reg   <= s2_hr_ok_reg ? ADD_W'(prod_hr >> HR_SHIFT) : '0;
            s3_add_s_reg    <= ADD_W'(prod_s >> SPD_SHIFT);
            s3_hr_en_reg    <= !s2_paused_reg && s2_hr_live_reg;
            s3_pwr_en_reg   <= !s2_paused_reg && s2_power_live_reg && (ftp_reg != 12'd0);
            s3_hr_zone_reg  <= hr_zone_next;
            s3_pwr_zone_reg <= pwr_zone_next;
            s3_session_reg  <= s2_session_reg;
        end
    end

    // Stage 4: pick the burn of the chosen source
    q_item_t item_next;

    always_comb
    begin
        item_next.source     = s3_source_reg;
        item_next.hr_en      = s3_hr_en_reg;
        item_next.hr_zone    = s3_hr_zone_reg;
        item_next.pwr_en     = s3_pwr_en_reg;
        item_next.pwr_zone   = s3_pwr_zone_reg;
        item_next.session_ms = s3_session_reg;
        case (s3_source_reg)
            SRC_POWER: item_next.add = s3_add_p_reg;
            SRC_HEART: item_next.add = s3_add_hr_reg;
            SRC_SPEED: item_next.add = s3_add_s_reg;
            default:   item_next.add = '0;
        endcase
    end

    q_item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign push_item = item_reg;

endmodule

FILE: src/rczt_queue.sv
// Short item queue between the front pipeline and the back accumulator
module rczt_queue
    import rczt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    input  q_item_t push_item,
    output logic    push_ready,
    output logic    pop_valid,
    output q_item_t pop_item,
    input  logic    pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    q_item_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: src/rczt_back.sv
// Back end: calorie total, zone time counters, zone change time, report register
module rczt_back
    import rczt_pkg::*;
#(
    parameter int HEART_ZONES = HEART_ZONES_DEF,
    parameter int POWER_ZONES = POWER_ZONES_DEF
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    input  q_item_t         pop_item,
    output logic            pop_ready,
    rczt_report_if.source   report
);

    localparam int HZ_IW = $clog2(HEART_ZONES + 1);
    localparam int PZ_IW = $clog2(POWER_ZONES + 1);
    localparam logic [31:0] TICK_MS = 32'd1000;

    logic [KCAL_W-1:0] kcal_reg, kcal_next;
    logic [31:0]       hr_times_reg  [HEART_ZONES + 1];
    logic [31:0]       pwr_times_reg [POWER_ZONES + 1];
    logic              last_valid_reg, last_valid_next;
    logic [ZONE_W-1:0] last_zone_reg;
    logic [31:0]       changed_at_reg, changed_at_next;

    logic              out_valid_reg;
    logic [1:0]        src_out_reg;
    logic [3:0]        hr_zone_out_reg, pwr_zone_out_reg;
    logic [31:0]       hr_time_out_reg, pwr_time_out_reg, since_out_reg;

    logic              take;
    logic [KCAL_W:0]   kcal_sum;
    logic [HZ_IW-1:0]  hr_idx;
    logic [PZ_IW-1:0]  pwr_idx;
    logic [31:0]       hr_cur, pwr_cur, hr_next, pwr_next;
    logic              zone_changed;

    assign pop_ready = !out_valid_reg || report.ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        kcal_sum  = {1'b0, kcal_reg} + (KCAL_W+1)'(pop_item.add);
        kcal_next = kcal_sum[KCAL_W] ? '1 : kcal_sum[KCAL_W-1:0];

        hr_idx  = pop_item.hr_zone[HZ_IW-1:0];
        pwr_idx = pop_item.pwr_zone[PZ_IW-1:0];
        hr_cur  = hr_times_reg[hr_idx];
        pwr_cur = pwr_times_reg[pwr_idx];
        hr_next  = (hr_cur > 32'hFFFF_FFFF - TICK_MS) ? '1 : hr_cur + TICK_MS;
        pwr_next = (pwr_cur > 32'hFFFF_FFFF - TICK_MS) ? '1 : pwr_cur + TICK_MS;

        zone_changed    = pop_item.hr_en && (!last_valid_reg || pop_item.hr_zone != last_zone_reg);
        changed_at_next = zone_changed ? pop_item.session_ms : changed_at_reg;
        last_valid_next = last_valid_reg || pop_item.hr_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kcal_reg       <= '0;
            last_valid_reg <= 1'b0;
            last_zone_reg  <= '0;
            changed_at_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i <= HEART_ZONES; i++)
                hr_times_reg[i] <= '0;
            for (int i = 0; i <= POWER_ZONES; i++)
                pwr_times_reg[i] <= '0;
        end
        else
        begin
            if (take)
            begin
                kcal_reg       <= kcal_next;
                last_valid_reg <= last_valid_next;
                changed_at_reg <= changed_at_next;
                if (zone_changed)
                    last_zone_reg <= pop_item.hr_zone;
                if (pop_item.hr_en)
                    hr_times_reg[hr_idx] <= hr_next;
                if (pop_item.pwr_en)
                    pwr_times_reg[pwr_idx] <= pwr_next;
                out_valid_reg <= 1'b1;
            end
            else if (report.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            src_out_reg      <= pop_item.source;
            hr_zone_out_reg  <= pop_item.hr_en ? {1'b0, pop_item.hr_zone} : ZONE_NONE;
            hr_time_out_reg  <= pop_item.hr_en ? hr_next : '0;
            pwr_zone_out_reg <= pop_item.pwr_en ? {1'b0, pop_item.pwr_zone} : ZONE_NONE;
            pwr_time_out_reg <= pop_item.pwr_en ? pwr_next : '0;
            since_out_reg    <= last_valid_next ? pop_item.session_ms - changed_at_next : '0;
        end
    end

    assign report.valid              = out_valid_reg;
    assign report.kcal_total_q16     = kcal_reg;
    assign report.kcal_source        = src_out_reg;
    assign report.hr_zone_now        = $signed(hr_zone_out_reg);
    assign report.hr_zone_time_ms    = hr_time_out_reg;
    assign report.power_zone_now     = $signed(pwr_zone_out_reg);
    assign report.power_zone_time_ms = pwr_time_out_reg;
    assign report.zone_since_ms      = since_out_reg;

endmodule

FILE: src/ride_calorie_and_zone_tracker_top.sv
// An accepted sample item passes the four front stages, the queue memory and the report register.
// Throughput: one item per cycle while the report port is not stalled; four front stages, a
// four-entry queue, and an accumulate step in the back end that updates total and zone counters.
// Reset (rst_n, asynchronous, active low) clears config, total, zone counters and the
// zone change record; the block is ready for items as soon as reset is released.
module ride_calorie_and_zone_tracker_top
    import rczt_pkg::*;
#(
    parameter int HEART_ZONES = HEART_ZONES_DEF,
    parameter int POWER_ZONES = POWER_ZONES_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rczt_sample_if.sink           sample,
    rczt_report_if.source         report
);

    cfg_wr_t cfg;
    logic    push_valid, push_ready, pop_valid, pop_ready;
    q_item_t push_item, pop_item;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index_t'(cfg_index);
    assign cfg.data  = cfg_data;

    rczt_front #(
        .HEART_ZONES (HEART_ZONES),
        .POWER_ZONES (POWER_ZONES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample     (sample),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    rczt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    rczt_back #(
        .HEART_ZONES (HEART_ZONES),
        .POWER_ZONES (POWER_ZONES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .report    (report)
    );

endmodule

FILE: src/rczt_checker.sv
// Port-level assertion checker for the tracker, bound to the top level
`include "ride_calorie_and_zone_tracker_top_macros.svh"

module rczt_checker
    import rczt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        report_valid,
    input logic        report_ready,
    input logic [47:0] kcal_total_q16,
    input logic [3:0]  hr_zone_now,
    input logic [31:0] hr_zone_time_ms,
    input logic [3:0]  power_zone_now,
    input logic [31:0] power_zone_time_ms
);

    logic [47:0] last_kcal_reg;
    logic        seen_reg;
    logic        report_fire;

    assign report_fire = report_valid && report_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            last_kcal_reg <= '0;
        end
        else if (report_fire)
        begin
            seen_reg      <= 1'b1;
            last_kcal_reg <= kcal_total_q16;
        end
    end

    `RCZT_ASSERT_NEXT(a_report_hold, report_valid && !report_ready, report_valid, "report item dropped while stalled")
    `RCZT_ASSERT_NEXT(a_report_stable, report_valid && !report_ready, $stable(kcal_total_q16) && $stable(hr_zone_time_ms), "report item changed while stalled")
    `RCZT_ASSERT_NOW(a_kcal_monotonic, report_fire && seen_reg, kcal_total_q16 >= last_kcal_reg, "calorie total decreased")
    `RCZT_ASSERT_NOW(a_hr_zone_time, report_valid, (hr_zone_now == ZONE_NONE && hr_zone_time_ms == 32'd0) || (hr_zone_now != ZONE_NONE && hr_zone_time_ms >= 32'd1000), "heart zone time inconsistent with zone")
    `RCZT_ASSERT_NOW(a_pwr_zone_time, report_valid, (power_zone_now == ZONE_NONE && power_zone_time_ms == 32'd0) || (power_zone_now != ZONE_NONE && power_zone_time_ms >= 32'd1000), "power zone time inconsistent with zone")

endmodule

bind ride_calorie_and_zone_tracker_top rczt_checker u_rczt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .report_valid       (report.valid),
    .report_ready       (report.ready),
    .kcal_total_q16     (report.kcal_total_q16),
    .hr_zone_now        (report.hr_zone_now),
    .hr_zone_time_ms    (report.hr_zone_time_ms),
    .power_zone_now     (report.power_zone_now),
    .power_zone_time_ms (report.power_zone_time_ms)
);
